### rtl/core/pss_pkg.sv
package pss_pkg;

  // sequencer phases, numeric codes are visible on the phase output
  typedef enum logic [3:0] {
    PhStop    = 4'd0,
    PhWatch   = 4'd1,
    PhRight0  = 4'd2,
    PhRight1  = 4'd3,
    PhRight2  = 4'd4,
    PhRight3  = 4'd5,
    PhLeft0   = 4'd6,
    PhLeft1   = 4'd7,
    PhLeft2   = 4'd8,
    PhLeft3   = 4'd9,
    PhBalance = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    CfgCenterAngle  = 3'd0,
    CfgCenterRange  = 3'd1,
    CfgKickDrive    = 3'd2,
    CfgKickTicks    = 3'd3,
    CfgWatchDivider = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [11:0] CenterAngleRst  = 12'd2010;
  localparam logic [10:0] CenterRangeRst  = 11'd500;
  localparam logic [6:0]  KickDriveRst    = 7'd35;
  localparam logic [15:0] KickTicksRst    = 16'd100;
  localparam logic [7:0]  WatchDividerRst = 8'd40;

  typedef struct packed {
    logic [11:0]        angle_sample;
    logic signed [15:0] encoder_speed;
    logic               start_toggle;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0]  motor_drive;
    logic               balance_active;
    logic               clear_integrators;
    logic signed [15:0] position_count;
    logic [3:0]         phase;
  } out_word_t;

  typedef struct packed {
    logic [11:0] upright_angle;
    logic [10:0] window_half;
    logic [6:0]  kick_drive;
    logic [15:0] kick_ticks;
    logic [7:0]  watch_divider;
  } pss_cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [7:0]         watch_cnt;
    logic [15:0]        kick_cnt;
    logic [11:0]        hist0;
    logic [11:0]        hist1;
    logic [11:0]        hist2;
    logic signed [15:0] position;
    logic signed [7:0]  drive;
  } pss_state_t;

endpackage

### rtl/core/pss_step.sv
module pss_step import pss_pkg::*; (
  input  pss_state_t state_i,
  input  in_word_t   word_i,
  input  pss_cfg_t   cfg_i,
  output pss_state_t state_o,
  output logic       clear_o
);

  logic signed [13:0] win_lo;
  logic signed [13:0] win_hi;
  logic signed [13:0] a0;
  logic signed [13:0] a1;
  logic signed [13:0] a2;
  phase_e             ph_t;
  phase_e             ph_d;
  logic [7:0]         wc_inc;
  logic               take;
  logic               right_peak;
  logic               left_peak;
  logic               center;
  logic               in_win_now;
  logic [15:0]        kc_dec;
  logic               kc_done;
  logic signed [7:0]  drive_pos;
  logic signed [7:0]  drive_neg;

  function automatic logic in_win(input logic signed [13:0] a,
                                  input logic signed [13:0] lo,
                                  input logic signed [13:0] hi);
    in_win = (a > lo) && (a < hi);
  endfunction

  assign win_lo = $signed({2'b00, cfg_i.upright_angle}) - $signed({3'b000, cfg_i.window_half});
  assign win_hi = $signed({2'b00, cfg_i.upright_angle}) + $signed({3'b000, cfg_i.window_half});

  // start/stop toggle acts before the sequence step
  assign ph_t = word_i.start_toggle ? ((state_i.phase == PhStop) ? PhRight0 : PhStop)
                                    : state_i.phase;

  assign wc_inc = state_i.watch_cnt + 8'd1;
  assign take   = (wc_inc >= cfg_i.watch_divider);

  // history as it stands after the shift
  assign a0 = $signed({2'b00, word_i.angle_sample});
  assign a1 = $signed({2'b00, state_i.hist0});
  assign a2 = $signed({2'b00, state_i.hist1});

  assign right_peak = (a0 > win_hi) && (a1 > win_hi) && (a2 > win_hi) && (a1 < a0) && (a1 < a2);
  assign left_peak  = (a0 < win_lo) && (a1 < win_lo) && (a2 < win_lo) && (a1 > a0) && (a1 > a2);
  assign center     = in_win(a0, win_lo, win_hi) && in_win(a1, win_lo, win_hi);
  assign in_win_now = in_win(a0, win_lo, win_hi);

  assign kc_dec  = state_i.kick_cnt - 16'd1;
  assign kc_done = (kc_dec == 16'd0);

  assign drive_pos = $signed({1'b0, cfg_i.kick_drive});
  assign drive_neg = 8'sd0 - drive_pos;

  // next phase
  always_comb begin
    unique case (ph_t)
      PhWatch: begin
        if (!take) ph_d = PhWatch;
        else if (center) ph_d = PhBalance;
        else if (left_peak) ph_d = PhLeft0;
        else if (right_peak) ph_d = PhRight0;
        else ph_d = PhWatch;
      end
      PhRight0:  ph_d = PhRight1;
      PhRight1:  ph_d = kc_done ? PhRight2 : PhRight1;
      PhRight2:  ph_d = PhRight3;
      PhRight3:  ph_d = kc_done ? PhWatch : PhRight3;
      PhLeft0:   ph_d = PhLeft1;
      PhLeft1:   ph_d = kc_done ? PhLeft2 : PhLeft1;
      PhLeft2:   ph_d = PhLeft3;
      PhLeft3:   ph_d = kc_done ? PhWatch : PhLeft3;
      PhBalance: ph_d = in_win_now ? PhBalance : PhStop;
      default:   ph_d = PhStop;
    endcase
  end

  // counters, history, drive and position
  always_comb begin
    state_o          = state_i;
    state_o.phase    = ph_d;
    state_o.position = state_i.position + word_i.encoder_speed;
    clear_o          = 1'b0;
    unique case (ph_t)
      PhWatch: begin
        state_o.watch_cnt = take ? 8'd0 : wc_inc;
        if (take) begin
          state_o.hist0 = word_i.angle_sample;
          state_o.hist1 = state_i.hist0;
          state_o.hist2 = state_i.hist1;
          if (center) begin
            state_o.position = 16'sd0;
            clear_o          = 1'b1;
          end
        end
      end
      PhRight0, PhLeft2: begin
        state_o.drive    = drive_pos;
        state_o.kick_cnt = cfg_i.kick_ticks;
      end
      PhRight2, PhLeft0: begin
        state_o.drive    = drive_neg;
        state_o.kick_cnt = cfg_i.kick_ticks;
      end
      PhRight1, PhLeft1: begin
        state_o.kick_cnt = kc_dec;
      end
      PhRight3, PhLeft3: begin
        state_o.kick_cnt = kc_dec;
        if (kc_done) state_o.drive = 8'sd0;
      end
      PhBalance: begin
        state_o.drive = state_i.drive;
      end
      default: begin
        state_o.drive = 8'sd0;
      end
    endcase
  end

endmodule

### rtl/core/pendulum_swing_up_sequencer_top.sv
// channel | signals                              | word
// --------+--------------------------------------+---------------------------------
// in      | in_valid_i, in_ready_o, in_word_i    | angle, encoder speed, toggle
// out     | out_valid_o, out_ready_i, out_word_o | drive, flags, position, phase
// cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | register write, no handshake
//
// one word per clock while out is not stalled: the whole tick step is one pass of
// logic from the sequencer registers into the result register, valid in the next cycle.
// a new word is taken while the result register is empty or being drained,
// so a stall on out only holds in back when a result is actually waiting.
// reset puts the sequencer in stopped with empty history and registers at
// their default values.
module pendulum_swing_up_sequencer_top import pss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  pss_cfg_t   cfg_q;
  pss_state_t state_q;
  pss_state_t state_d;
  logic       clear;
  logic       accept;
  logic       out_valid_q;
  out_word_t  out_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upright_angle <= CenterAngleRst;
      cfg_q.window_half   <= CenterRangeRst;
      cfg_q.kick_drive    <= KickDriveRst;
      cfg_q.kick_ticks    <= KickTicksRst;
      cfg_q.watch_divider <= WatchDividerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCenterAngle:  cfg_q.upright_angle <= cfg_wdata_i[11:0];
        CfgCenterRange:  cfg_q.window_half   <= cfg_wdata_i[10:0];
        CfgKickDrive:    cfg_q.kick_drive    <= cfg_wdata_i[6:0];
        CfgKickTicks:    cfg_q.kick_ticks    <= cfg_wdata_i[15:0];
        CfgWatchDivider: cfg_q.watch_divider <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  pss_step u_step (
    .state_i (state_q),
    .word_i  (in_word_i),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .clear_o (clear)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PhStop;
      state_q.watch_cnt <= '0;
      state_q.kick_cnt  <= '0;
      state_q.hist0     <= '0;
      state_q.hist1     <= '0;
      state_q.hist2     <= '0;
      state_q.position  <= '0;
      state_q.drive     <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      if (accept) state_q <= state_d;
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.motor_drive       <= state_d.drive;
      out_q.balance_active    <= (state_d.phase == PhBalance);
      out_q.clear_integrators <= clear;
      out_q.position_count    <= state_d.position;
      out_q.phase             <= state_d.phase;
    end
  end

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word did not reach the result register");

  a_clear_enters_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.clear_integrators) |->
      (out_q.balance_active && out_q.position_count == 16'sd0))
    else $error("integrator clear without balance entry");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PhBalance)
    else $error("sequencer in unused phase code");

  a_drive_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PhStop || state_q.phase == PhWatch) |-> state_q.drive == 8'sd0)
    else $error("drive held outside a kick");
`endif

endmodule
